// ===== rtl/lbs_pkg.sv =====
// LED blink sequencer shared package: operation and mode codes, item and
// result types, default tick length. No dependencies.
package lbs_pkg;

    localparam int unsigned TICK_MS_DEFAULT = 100;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SET_LIGHT   = 2'd1,
        OP_START_FLASH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_TIMED     = 2'd0,
        MODE_COUNTED   = 2'd1,
        MODE_FOREVER   = 2'd2,
        MODE_NO_COUNT  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic        light_on;
        logic [1:0]  flash_mode;
        logic [1:0]  flash_type;
        logic [15:0] on_time;
        logic [15:0] dark_time;
        logic [31:0] total;
    } item_t;

    typedef struct packed {
        logic pin_level;
        logic led_lit;
        logic flashing;
        logic flash_finished;
    } result_t;

endpackage

// ===== rtl/lbs_in_stage.sv =====
// Input register of the LED blink sequencer: holds one accepted beat.
// Depends on lbs_pkg.
module lbs_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lbs_pkg::item_t in_item,
    input  logic          advance,
    output logic          s1_valid,
    output lbs_pkg::item_t s1_item
);

    logic           valid_reg;
    logic           valid_next;
    lbs_pkg::item_t item_reg;

    // free when empty or when the held beat moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

// ===== rtl/lbs_core.sv =====
// Flash state and single-pass update logic of the LED blink sequencer.
// Depends on lbs_pkg.
module lbs_core
#(
    parameter int unsigned TICK_MS = lbs_pkg::TICK_MS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             advance,
    input  lbs_pkg::item_t   item,
    output lbs_pkg::result_t result
);

    localparam logic [31:0] TICK = 32'(TICK_MS);

    logic        pin_invert_reg;
    logic        lit_reg, lit_next;
    logic        active_flash_reg, active_flash_next;
    logic        stop_pending_reg, stop_pending_next;
    logic        stop_level_reg, stop_level_next;
    logic [1:0]  mode_held_reg, mode_held_next;
    logic [1:0]  type_held_reg, type_held_next;
    logic [15:0] on_len_reg, on_len_next;
    logic [15:0] off_len_reg, off_len_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] elapsed_reg, elapsed_next;

    // tick datapath
    logic [16:0] period;
    logic        first_level;
    logic [15:0] first_len;
    logic [31:0] elapsed_inc;
    logic        wrap;
    logic        past_first;
    logic [31:0] rem_timed;
    logic [31:0] rem_counted;
    logic        finished;

    assign period      = {1'b0, on_len_reg} + {1'b0, off_len_reg};
    assign first_level = ~type_held_reg[1];
    assign first_len   = first_level ? on_len_reg : off_len_reg;
    assign elapsed_inc = elapsed_reg + TICK;
    assign wrap        = elapsed_inc >= {15'd0, period};
    assign past_first  = elapsed_inc >= {16'd0, first_len};
    assign rem_timed   = (remaining_reg > TICK) ? remaining_reg - TICK : 32'd0;
    assign rem_counted = (wrap && remaining_reg != 32'd0) ? remaining_reg - 32'd1
                                                          : remaining_reg;

    always_comb
    begin
        lit_next          = lit_reg;
        active_flash_next = active_flash_reg;
        stop_pending_next = stop_pending_reg;
        stop_level_next   = stop_level_reg;
        mode_held_next    = mode_held_reg;
        type_held_next    = type_held_reg;
        on_len_next       = on_len_reg;
        off_len_next      = off_len_reg;
        remaining_next    = remaining_reg;
        elapsed_next      = elapsed_reg;
        finished          = 1'b0;

        case (item.operation)
            lbs_pkg::OP_TICK:
            begin
                if (stop_pending_reg)
                begin
                    // deferred stop ends the flash before anything else
                    lit_next          = stop_level_reg;
                    active_flash_next = 1'b0;
                    stop_pending_next = 1'b0;
                end
                else if (active_flash_reg)
                begin
                    if (wrap)
                    begin
                        elapsed_next = elapsed_inc - {15'd0, period};
                        lit_next     = first_level;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                        if (past_first)
                        begin
                            lit_next = ~first_level;
                        end
                    end

                    if (mode_held_reg != lbs_pkg::MODE_FOREVER)
                    begin
                        case (mode_held_reg)
                            lbs_pkg::MODE_TIMED:   remaining_next = rem_timed;
                            lbs_pkg::MODE_COUNTED: remaining_next = rem_counted;
                            default:               remaining_next = remaining_reg;
                        endcase
                        if (remaining_next == 32'd0)
                        begin
                            finished          = 1'b1;
                            stop_pending_next = 1'b1;
                            stop_level_next   = ~type_held_reg[0];
                        end
                    end
                end
            end
            lbs_pkg::OP_SET_LIGHT:
            begin
                if (active_flash_reg)
                begin
                    stop_pending_next = 1'b1;
                    stop_level_next   = item.light_on;
                end
                else
                begin
                    lit_next = item.light_on;
                end
            end
            lbs_pkg::OP_START_FLASH:
            begin
                stop_pending_next = 1'b0;
                active_flash_next = 1'b1;
                mode_held_next    = item.flash_mode;
                type_held_next    = item.flash_type;
                on_len_next       = item.on_time;
                off_len_next      = item.dark_time;
                remaining_next    = item.total;
                elapsed_next      = 32'd0;
                lit_next          = ~item.flash_type[1];
            end
            default:
            begin
                lit_next = lit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_invert_reg   <= 1'b0;
            lit_reg          <= 1'b0;
            active_flash_reg <= 1'b0;
            stop_pending_reg <= 1'b0;
            stop_level_reg   <= 1'b0;
            mode_held_reg    <= 2'd0;
            type_held_reg    <= 2'd0;
            on_len_reg       <= 16'd0;
            off_len_reg      <= 16'd0;
            remaining_reg    <= 32'd0;
            elapsed_reg      <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pin_invert_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                lit_reg          <= lit_next;
                active_flash_reg <= active_flash_next;
                stop_pending_reg <= stop_pending_next;
                stop_level_reg   <= stop_level_next;
                mode_held_reg    <= mode_held_next;
                type_held_reg    <= type_held_next;
                on_len_reg       <= on_len_next;
                off_len_reg      <= off_len_next;
                remaining_reg    <= remaining_next;
                elapsed_reg      <= elapsed_next;
            end
        end
    end

    assign result.pin_level      = lit_next ^ pin_invert_reg;
    assign result.led_lit        = lit_next;
    assign result.flashing       = active_flash_next;
    assign result.flash_finished = finished;

endmodule

// ===== rtl/lbs_out_reg.sv =====
// Result register of the LED blink sequencer with valid/ready output.
// Depends on lbs_pkg.
module lbs_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lbs_pkg::result_t result_in,
    output logic             out_valid,
    input  logic             out_ready,
    output lbs_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    lbs_pkg::result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== rtl/led_blink_sequencer.sv =====
// LED blink sequencer top level: input register, flash state update, result
// register. Depends on lbs_pkg, lbs_in_stage, lbs_core, lbs_out_reg.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | operation light_on flash_mode flash_type
//          |                       | on_time dark_time total
//  out     | out_valid / out_ready | pin_level led_lit flashing flash_finished
//  cfg     | cfg_wr_en             | cfg_wr_data (pin_invert)
//
// One beat per cycle sustained while out_ready is high; an accepted beat is held in the
// input register, and its result is loaded into the result register when it advances.
// The state update is one pass of logic between the input register and the
// result register: a 32-bit tick add feeding the period compare and subtract.
// Stalls: a full result register holds the input register, which in turn
// drops in_ready; both sides may stall freely with no loss.
// Reset (rst_n, async, active low) clears all flash state and pin_invert.
module led_blink_sequencer
#(
    parameter int unsigned TICK_MS = lbs_pkg::TICK_MS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        light_on,
    input  logic [1:0]  flash_mode,
    input  logic [1:0]  flash_type,
    input  logic [15:0] on_time,
    input  logic [15:0] dark_time,
    input  logic [31:0] total,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        pin_level,
    output logic        led_lit,
    output logic        flashing,
    output logic        flash_finished
);

    lbs_pkg::item_t   in_item;
    lbs_pkg::item_t   s1_item;
    lbs_pkg::result_t core_result;
    lbs_pkg::result_t out_result;
    logic             s1_valid;
    logic             advance;

    assign in_item.operation  = operation;
    assign in_item.light_on   = light_on;
    assign in_item.flash_mode = flash_mode;
    assign in_item.flash_type = flash_type;
    assign in_item.on_time    = on_time;
    assign in_item.dark_time  = dark_time;
    assign in_item.total      = total;

    // the held beat commits its state update when the result register
    // is empty or being drained this cycle
    assign advance = s1_valid && (!out_valid || out_ready);

    lbs_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    lbs_core #(
        .TICK_MS (TICK_MS)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (s1_item),
        .result      (core_result)
    );

    lbs_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign pin_level      = out_result.pin_level;
    assign led_lit        = out_result.led_lit;
    assign flashing       = out_result.flashing;
    assign flash_finished = out_result.flash_finished;

endmodule
